// File: hdl/cau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and saturation helpers of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int WW    = 32;
  localparam int FB    = 16;
  localparam int PW    = 2 * WW;
  localparam int DVW   = PW + FB;
  localparam int NCELL = DVW;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MAG = 3'd4;

  typedef struct packed {
    logic [2:0]           opcode;
    logic signed [WW-1:0] a_re;
    logic signed [WW-1:0] a_im;
    logic signed [WW-1:0] b_re;
    logic signed [WW-1:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [WW-1:0] res_re;
    logic signed [WW-1:0] res_im;
    logic                 overflow;
    logic                 div_by_zero;
  } out_t;

  typedef struct packed {
    logic [DVW-1:0] dvd;
    logic [PW-1:0]  rem;
    logic [PW-1:0]  den;
    logic [WW-1:0]  q;
    logic           big;
    logic           neg;
  } lane_t;

  typedef struct packed {
    logic is_div;
    logic dz;
    out_t direct;
  } meta_t;

  typedef struct packed {
    logic [WW-1:0] val;
    logic          ovf;
  } sat_t;

  function automatic sat_t sat_word(input logic signed [PW:0] v);
    logic [PW-WW+1:0] hi;
    sat_t r;
    hi = v[PW:WW-1];
    if ((&hi) || !(|hi)) begin
      r.val = v[WW-1:0];
      r.ovf = 1'b0;
    end else if (v[PW]) begin
      r.val = {1'b1, {(WW-1){1'b0}}};
      r.ovf = 1'b1;
    end else begin
      r.val = {1'b0, {(WW-1){1'b1}}};
      r.ovf = 1'b1;
    end
    return r;
  endfunction

  function automatic sat_t quot_word(input logic [WW-1:0] q, input logic big, input logic neg);
    logic [WW-1:0] nq;
    sat_t r;
    nq = -q;
    if (neg) begin
      if (big || (q[WW-1] && (|q[WW-2:0]))) begin
        r.val = {1'b1, {(WW-1){1'b0}}};
        r.ovf = 1'b1;
      end else begin
        r.val = nq;
        r.ovf = 1'b0;
      end
    end else begin
      if (big || q[WW-1]) begin
        r.val = {1'b0, {(WW-1){1'b1}}};
        r.ovf = 1'b1;
      end else begin
        r.val = q;
        r.ovf = 1'b0;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/cau_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring division step: one quotient bit per cell, registered.
// ----------------------------------------------------------------------------
module cau_div_cell (
  input  wire logic          clk,
  input  wire cau_pkg::lane_t lane_in,
  output cau_pkg::lane_t     lane_out
);
  import cau_pkg::*;

  lane_t       lane_r;
  lane_t       lane_nxt;
  logic [PW:0] sh;
  logic [PW:0] diff;
  logic        ge;

  always_comb begin
    sh   = {lane_in.rem, lane_in.dvd[DVW-1]};
    diff = sh - {1'b0, lane_in.den};
    ge   = (sh >= {1'b0, lane_in.den});
    lane_nxt.dvd = {lane_in.dvd[DVW-2:0], 1'b0};
    lane_nxt.rem = ge ? diff[PW-1:0] : sh[PW-1:0];
    lane_nxt.den = lane_in.den;
    lane_nxt.q   = {lane_in.q[WW-2:0], ge};
    lane_nxt.big = lane_in.big | lane_in.q[WW-1];
    lane_nxt.neg = lane_in.neg;
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign lane_out = lane_r;

endmodule
`default_nettype wire

// File: hdl/cau_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Operand sign split, products, sums and direct results; divider lane setup.
// ----------------------------------------------------------------------------
module cau_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire cau_pkg::in_t    in_data,
  output logic                 out_valid,
  output cau_pkg::meta_t       out_meta,
  output cau_pkg::lane_t       out_re,
  output cau_pkg::lane_t       out_im
);
  import cau_pkg::*;

  function automatic logic signed [PW:0] to_sgn(input logic s, input logic [PW-1:0] m);
    logic signed [PW:0] p;
    p = {1'b0, m};
    return s ? -p : p;
  endfunction

  // stage 1
  logic                 v1_r;
  logic [2:0]           op1_r;
  logic [WW-1:0]        am1_r, bm1_r, cm1_r, dm1_r;
  logic                 an1_r, bn1_r, cn1_r, dn1_r;
  logic signed [WW:0]   sre1_r, sim1_r;
  logic signed [WW:0]   sre1_nxt, sim1_nxt;
  logic [WW-1:0]        na, nb, nc, nd;

  // stage 2
  logic                 v2_r;
  logic [2:0]           op2_r;
  logic [PW-1:0]        m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  logic                 s0_r, s1_r, s2_r, s3_r;
  logic signed [WW:0]   sre2_r, sim2_r;
  logic [WW-1:0]        sel0, sel1;
  logic                 ssel0, ssel1;

  // stage 3
  logic                 v3_r;
  logic [2:0]           op3_r;
  logic signed [PW:0]   vre3_r, vim3_r, vre3_nxt, vim3_nxt;
  logic [PW-1:0]        den3_r;
  logic signed [PW:0]   t0, t1, t2, t3;

  // stage 4
  logic                 v4_r;
  meta_t                meta4_r, meta4_nxt;
  lane_t                lre4_r, lim4_r, lre4_nxt, lim4_nxt;
  sat_t                 sr, si;
  logic [PW-1:0]        mre, mim;

  always_comb begin
    na = -in_data.a_re;
    nb = -in_data.a_im;
    nc = -in_data.b_re;
    nd = -in_data.b_im;
    if (in_data.opcode == OP_SUB) begin
      sre1_nxt = {in_data.a_re[WW-1], in_data.a_re} - {in_data.b_re[WW-1], in_data.b_re};
      sim1_nxt = {in_data.a_im[WW-1], in_data.a_im} - {in_data.b_im[WW-1], in_data.b_im};
    end else begin
      sre1_nxt = {in_data.a_re[WW-1], in_data.a_re} + {in_data.b_re[WW-1], in_data.b_re};
      sim1_nxt = {in_data.a_im[WW-1], in_data.a_im} + {in_data.b_im[WW-1], in_data.b_im};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    op1_r  <= in_data.opcode;
    an1_r  <= in_data.a_re[WW-1];
    bn1_r  <= in_data.a_im[WW-1];
    cn1_r  <= in_data.b_re[WW-1];
    dn1_r  <= in_data.b_im[WW-1];
    am1_r  <= in_data.a_re[WW-1] ? na : in_data.a_re;
    bm1_r  <= in_data.a_im[WW-1] ? nb : in_data.a_im;
    cm1_r  <= in_data.b_re[WW-1] ? nc : in_data.b_re;
    dm1_r  <= in_data.b_im[WW-1] ? nd : in_data.b_im;
    sre1_r <= sre1_nxt;
    sim1_r <= sim1_nxt;
  end

  always_comb begin
    sel0  = (op1_r == OP_MAG) ? am1_r : cm1_r;
    sel1  = (op1_r == OP_MAG) ? bm1_r : dm1_r;
    ssel0 = (op1_r == OP_MAG) ? an1_r : cn1_r;
    ssel1 = (op1_r == OP_MAG) ? bn1_r : dn1_r;
  end

  always_ff @(posedge clk) begin
    op2_r  <= op1_r;
    m0_r   <= PW'(am1_r) * PW'(sel0);
    m1_r   <= PW'(bm1_r) * PW'(sel1);
    m2_r   <= PW'(am1_r) * PW'(dm1_r);
    m3_r   <= PW'(bm1_r) * PW'(cm1_r);
    m4_r   <= PW'(cm1_r) * PW'(cm1_r);
    m5_r   <= PW'(dm1_r) * PW'(dm1_r);
    s0_r   <= an1_r ^ ssel0;
    s1_r   <= bn1_r ^ ssel1;
    s2_r   <= an1_r ^ dn1_r;
    s3_r   <= bn1_r ^ cn1_r;
    sre2_r <= sre1_r;
    sim2_r <= sim1_r;
  end

  always_comb begin
    t0 = to_sgn(s0_r, m0_r);
    t1 = to_sgn(s1_r, m1_r);
    t2 = to_sgn(s2_r, m2_r);
    t3 = to_sgn(s3_r, m3_r);
    vre3_nxt = '0;
    vim3_nxt = '0;
    unique case (op2_r)
      OP_ADD, OP_SUB: begin
        vre3_nxt = {{(PW-WW){sre2_r[WW]}}, sre2_r};
        vim3_nxt = {{(PW-WW){sim2_r[WW]}}, sim2_r};
      end
      OP_MUL: begin
        vre3_nxt = t0 - t1;
        vim3_nxt = t2 + t3;
      end
      OP_DIV: begin
        vre3_nxt = t0 + t1;
        vim3_nxt = t3 - t2;
      end
      OP_MAG: begin
        vre3_nxt = t0 + t1;
      end
      default: begin
        vre3_nxt = '0;
        vim3_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op3_r  <= op2_r;
    vre3_r <= vre3_nxt;
    vim3_r <= vim3_nxt;
    den3_r <= m4_r + m5_r;
  end

  always_comb begin
    if (op3_r == OP_MUL || op3_r == OP_MAG) begin
      sr = sat_word(vre3_r >>> FB);
      si = sat_word(vim3_r >>> FB);
    end else begin
      sr = sat_word(vre3_r);
      si = sat_word(vim3_r);
    end
    mre = vre3_r[PW] ? PW'(-vre3_r) : vre3_r[PW-1:0];
    mim = vim3_r[PW] ? PW'(-vim3_r) : vim3_r[PW-1:0];

    meta4_nxt.is_div = (op3_r == OP_DIV);
    meta4_nxt.dz     = (op3_r == OP_DIV) && (den3_r == '0);
    if (op3_r == OP_ADD || op3_r == OP_SUB || op3_r == OP_MUL || op3_r == OP_MAG) begin
      meta4_nxt.direct.res_re   = sr.val;
      meta4_nxt.direct.res_im   = si.val;
      meta4_nxt.direct.overflow = sr.ovf | si.ovf;
    end else begin
      meta4_nxt.direct.res_re   = '0;
      meta4_nxt.direct.res_im   = '0;
      meta4_nxt.direct.overflow = 1'b0;
    end
    meta4_nxt.direct.div_by_zero = 1'b0;

    lre4_nxt.dvd = {mre, {FB{1'b0}}};
    lre4_nxt.rem = '0;
    lre4_nxt.den = den3_r;
    lre4_nxt.q   = '0;
    lre4_nxt.big = 1'b0;
    lre4_nxt.neg = vre3_r[PW];
    lim4_nxt.dvd = {mim, {FB{1'b0}}};
    lim4_nxt.rem = '0;
    lim4_nxt.den = den3_r;
    lim4_nxt.q   = '0;
    lim4_nxt.big = 1'b0;
    lim4_nxt.neg = vim3_r[PW];
  end

  always_ff @(posedge clk) begin
    meta4_r <= meta4_nxt;
    lre4_r  <= lre4_nxt;
    lim4_r  <= lim4_nxt;
  end

  assign out_valid = v4_r;
  assign out_meta  = meta4_r;
  assign out_re    = lre4_r;
  assign out_im    = lim4_r;

endmodule
`default_nettype wire

// File: hdl/complex_arith_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arith_unit_top
// Complex add, subtract, multiply, divide and squared magnitude on Q16.16.
//
//   channel  ports                   handshake
//   input    start, busy, in_data    request taken when start and not busy
//   result   out_valid, out_data     one-cycle strobe, no back pressure
//
// one request per cycle, busy stays low
// path: 4 front stages, 80 division cells, 1 output register
// every opcode takes the full division chain so results leave in order
// synchronous active-low reset clears the valid pipeline only
// ----------------------------------------------------------------------------
module complex_arith_unit_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire cau_pkg::in_t  in_data,
  output logic               out_valid,
  output cau_pkg::out_t      out_data
);
  import cau_pkg::*;

  logic  f_valid;
  meta_t f_meta;
  lane_t lre [NCELL+1];
  lane_t lim [NCELL+1];
  logic  vld_r  [NCELL];
  meta_t meta_r [NCELL];
  logic  out_valid_r;
  out_t  out_data_r, out_data_nxt;
  sat_t  qr, qi;

  assign busy = 1'b0;

  cau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_meta  (f_meta),
    .out_re    (lre[0]),
    .out_im    (lim[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cau_div_cell u_re (.clk(clk), .lane_in(lre[i]), .lane_out(lre[i+1]));
    cau_div_cell u_im (.clk(clk), .lane_in(lim[i]), .lane_out(lim[i+1]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= (i == 0) ? f_valid : vld_r[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk) begin
      meta_r[i] <= (i == 0) ? f_meta : meta_r[(i == 0) ? 0 : i-1];
    end
  end

  always_comb begin
    qr = quot_word(lre[NCELL].q, lre[NCELL].big, lre[NCELL].neg);
    qi = quot_word(lim[NCELL].q, lim[NCELL].big, lim[NCELL].neg);
    if (!meta_r[NCELL-1].is_div) begin
      out_data_nxt = meta_r[NCELL-1].direct;
    end else if (meta_r[NCELL-1].dz) begin
      out_data_nxt.res_re      = '0;
      out_data_nxt.res_im      = '0;
      out_data_nxt.overflow    = 1'b0;
      out_data_nxt.div_by_zero = 1'b1;
    end else begin
      out_data_nxt.res_re      = qr.val;
      out_data_nxt.res_im      = qi.val;
      out_data_nxt.overflow    = qr.ovf | qi.ovf;
      out_data_nxt.div_by_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[NCELL-1];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the complex arithmetic unit: directed corner requests
// followed by bursty random requests, every result compared against a literal
// expected value or a wide-precision software model kept in this file.
// ----------------------------------------------------------------------------
module tb;
  import cau_pkg::*;

  localparam int N_RAND = 450;
  localparam int LIMIT  = 200000;
  localparam logic signed [WW-1:0] WMAX = 32'sh7fffffff;
  localparam logic signed [WW-1:0] WMIN = 32'sh80000000;
  localparam logic signed [WW-1:0] ONE  = 32'sh00010000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  out_t pending_q[$];
  int   cycles;
  int   errors;

  complex_arith_unit_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  function automatic logic signed [WW-1:0] clamp_word(input logic signed [127:0] v,
                                                     inout logic ovf);
    if (v > 128'sh7fffffff) begin
      ovf = 1'b1;
      return WMAX;
    end else if (v < -128'sh80000000) begin
      ovf = 1'b1;
      return WMIN;
    end
    return v[WW-1:0];
  endfunction

  function automatic logic signed [127:0] scaled_quotient(input logic signed [127:0] num,
                                                          input logic signed [127:0] den);
    logic signed [127:0] mag;
    logic signed [127:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FB) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic out_t complex_result(input in_t x);
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    logic ovf;
    out_t r;
    ar = 128'(x.a_re); ai = 128'(x.a_im); br = 128'(x.b_re); bi = 128'(x.b_im);
    re = '0; im = '0; ovf = 1'b0;
    r = '0;
    case (x.opcode)
      OP_ADD: begin
        re = ar + br; im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br; im = ai - bi;
      end
      OP_MUL: begin
        re = (ar * br - ai * bi) >>> FB;
        im = (ar * bi + ai * br) >>> FB;
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_by_zero = 1'b1;
          return r;
        end
        re = scaled_quotient(ar * br + ai * bi, den);
        im = scaled_quotient(ai * br - ar * bi, den);
      end
      OP_MAG: begin
        re = (ar * ar + ai * ai) >>> FB;
      end
      default: return r;
    endcase
    r.res_re = clamp_word(re, ovf);
    r.res_im = clamp_word(im, ovf);
    r.overflow = ovf;
    return r;
  endfunction

  function automatic in_t mk(input logic [2:0] op, input logic signed [WW-1:0] ar,
                             input logic signed [WW-1:0] ai, input logic signed [WW-1:0] br,
                             input logic signed [WW-1:0] bi);
    in_t x;
    x.opcode = op; x.a_re = ar; x.a_im = ai; x.b_re = br; x.b_im = bi;
    return x;
  endfunction

  function automatic out_t mk_res(input logic signed [WW-1:0] re,
                                  input logic signed [WW-1:0] im,
                                  input logic ovf, input logic dz);
    out_t r;
    r.res_re = re; r.res_im = im; r.overflow = ovf; r.div_by_zero = dz;
    return r;
  endfunction

  function automatic logic signed [WW-1:0] rand_word();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
      2: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
      3: begin
        case ($urandom_range(0, 4))
          0: return WMAX;
          1: return WMIN;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
    endcase
  endfunction

  // issue one request, keep start high so back-to-back requests need no toggle
  task automatic send_request(input in_t x, input bit has_exp, input out_t e);
    start <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (busy);
    pending_q.push_back(has_exp ? e : complex_result(x));
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_data.res_re !== e.res_re) begin
          $display("%0t res_re exp %h got %h", $time, e.res_re, out_data.res_re);
          errors++;
        end
        if (out_data.res_im !== e.res_im) begin
          $display("%0t res_im exp %h got %h", $time, e.res_im, out_data.res_im);
          errors++;
        end
        if (out_data.overflow !== e.overflow) begin
          $display("%0t overflow exp %b got %b", $time, e.overflow, out_data.overflow);
          errors++;
        end
        if (out_data.div_by_zero !== e.div_by_zero) begin
          $display("%0t div_by_zero exp %b got %b", $time, e.div_by_zero,
                   out_data.div_by_zero);
          errors++;
        end
      end
    end
  end

  initial begin
    in_t  dir_req[$];
    bit   dir_has[$];
    out_t dir_exp[$];
    in_t  x;
    int   burst;
    int   sent;
    int   waited;

    cycles = 0;
    errors = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: request, whether a literal result is given, that result
    dir_req.push_back(mk(OP_ADD, WMAX, 0, WMAX, 0));
    dir_has.push_back(1'b1); dir_exp.push_back(mk_res(WMAX, 0, 1'b1, 1'b0));
    dir_req.push_back(mk(OP_ADD, 0, WMIN, 0, WMIN));
    dir_has.push_back(1'b1); dir_exp.push_back(mk_res(0, WMIN, 1'b1, 1'b0));
    dir_req.push_back(mk(OP_SUB, WMIN, 0, 1, 0));
    dir_has.push_back(1'b1); dir_exp.push_back(mk_res(WMIN, 0, 1'b1, 1'b0));
    dir_req.push_back(mk(OP_SUB, 0, 0, WMIN, 0));
    dir_has.push_back(1'b1); dir_exp.push_back(mk_res(WMAX, 0, 1'b1, 1'b0));
    dir_req.push_back(mk(OP_ADD, ONE, ONE, ONE, -ONE));
    dir_has.push_back(1'b1); dir_exp.push_back(mk_res(2 * ONE, 0, 1'b0, 1'b0));
    dir_req.push_back(mk(OP_DIV, WMAX, WMIN, 0, 0));
    dir_has.push_back(1'b1); dir_exp.push_back(mk_res(0, 0, 1'b0, 1'b1));
    dir_req.push_back(mk(OP_DIV, 0, 0, 0, 0));
    dir_has.push_back(1'b1); dir_exp.push_back(mk_res(0, 0, 1'b0, 1'b1));
    dir_req.push_back(mk(3'd5, WMAX, WMAX, WMAX, WMAX));
    dir_has.push_back(1'b1); dir_exp.push_back(mk_res(0, 0, 1'b0, 1'b0));
    dir_req.push_back(mk(3'd6, WMIN, WMIN, WMIN, WMIN));
    dir_has.push_back(1'b1); dir_exp.push_back(mk_res(0, 0, 1'b0, 1'b0));
    dir_req.push_back(mk(3'd7, -1, -1, -1, -1));
    dir_has.push_back(1'b1); dir_exp.push_back(mk_res(0, 0, 1'b0, 1'b0));
    dir_req.push_back(mk(OP_MUL, ONE, 0, ONE, 0));
    dir_has.push_back(1'b1); dir_exp.push_back(mk_res(ONE, 0, 1'b0, 1'b0));
    dir_req.push_back(mk(OP_MUL, -1, 0, 1, 0));
    dir_req.push_back(mk(OP_MUL, WMAX, WMAX, WMAX, WMAX));
    dir_req.push_back(mk(OP_MUL, WMIN, WMIN, WMIN, WMIN));
    dir_req.push_back(mk(OP_MUL, WMIN, 0, WMIN, 0));
    dir_req.push_back(mk(OP_MAG, WMIN, WMIN, 0, 0));
    dir_req.push_back(mk(OP_MAG, -1, 1, 0, 0));
    dir_req.push_back(mk(OP_MAG, 3 * ONE, 4 * ONE, WMAX, WMIN));
    dir_req.push_back(mk(OP_DIV, WMAX, WMAX, 1, 0));
    dir_req.push_back(mk(OP_DIV, WMIN, 0, 0, -1));
    dir_req.push_back(mk(OP_DIV, ONE, ONE, WMIN, WMIN));
    dir_req.push_back(mk(OP_DIV, 7 * ONE, -3 * ONE, 2 * ONE, ONE));
    dir_req.push_back(mk(OP_DIV, -1, 1, WMAX, WMAX));
    dir_req.push_back(mk(OP_SUB, WMAX, WMIN, WMAX, WMIN));
    while (dir_has.size() < dir_req.size()) begin
      dir_has.push_back(1'b0);
      dir_exp.push_back('0);
    end

    foreach (dir_req[i]) begin
      send_request(dir_req[i], dir_has[i], dir_exp[i]);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 3));
    end

    sent = 0;
    while (sent < N_RAND) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if ($urandom_range(0, 9) < 9) x.opcode = 3'($urandom_range(0, 4));
        else x.opcode = 3'($urandom_range(5, 7));
        x.a_re = rand_word(); x.a_im = rand_word();
        x.b_re = rand_word(); x.b_im = rand_word();
        if (x.opcode == OP_DIV && $urandom_range(0, 9) == 0) begin
          x.b_re = 0; x.b_im = 0;
        end
        send_request(x, 1'b0, '0);
        sent++;
      end
      if (sent > N_RAND / 2 && sent - burst <= N_RAND / 2) begin
        // drain the pipeline once mid-run
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end else begin
        idle_gap($urandom_range(0, 6));
      end
    end
    start <= 1'b0;

    waited = 0;
    while (pending_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (90) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/cau_pkg.sv
hdl/cau_div_cell.sv
hdl/cau_front.sv
hdl/complex_arith_unit_top.sv
sim/tb.sv
